[rtl/pcc_pkg.sv]
// Shared types, constants and codes for the colon path converter.
package pcc_pkg;

  localparam int VOL_MAX_DEFAULT = 32;
  localparam int LA_DEPTH        = 8;
  localparam int VOL_BYTES_HW    = 32;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Datapath operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_FHELD = 2'd1;
  localparam logic [1:0] OP_TERM  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Push byte source
  localparam logic SEL_LIT = 1'b0;
  localparam logic SEL_VOL = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_VOL_LEN = 3'd0;
  localparam logic [2:0] REG_WORD0   = 3'd1;
  localparam logic [2:0] REG_WORD1   = 3'd2;
  localparam logic [2:0] REG_WORD2   = 3'd3;
  localparam logic [2:0] REG_WORD3   = 3'd4;
  localparam logic [2:0] REG_LIMIT   = 3'd5;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
    logic       sel;
    logic [7:0] lit;
    logic [4:0] vidx;
  } pcc_cmd_t;

  typedef struct packed {
    logic       rdy;
    logic [5:0] vol_len;
  } pcc_stat_t;

  // "Volumes/" prefix byte at position i
  function automatic logic [7:0] vol_prefix(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h56;
      3'd1:    b = 8'h6F;
      3'd2:    b = 8'h6C;
      3'd3:    b = 8'h75;
      3'd4:    b = 8'h6D;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h73;
      default: b = CH_SLASH;
    endcase
    return b;
  endfunction

endpackage

[rtl/pcc_dpath.sv]
// Datapath: config registers, held colon, emitted count and output beat register.
module pcc_dpath import pcc_pkg::*; #(
  parameter int VOLUME_MAX_BYTES = VOL_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  pcc_cmd_t    cmd,
  output pcc_stat_t   stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_path
);

  localparam int LEN_CAP = (VOLUME_MAX_BYTES < VOL_BYTES_HW) ? VOLUME_MAX_BYTES : VOL_BYTES_HW;

  logic [5:0]   vol_len_r;
  logic [255:0] vol_r;
  logic [12:0]  limit_r;
  logic         held_r, held_nxt;
  logic [7:0]   prev_r, prev_nxt;
  logic [12:0]  cnt_r, cnt_nxt;
  logic         pend_r, pend_nxt;
  logic [7:0]   pend_byte_r, pend_byte_nxt;
  logic         ov_r, ov_nxt;
  logic [7:0]   ob_r, ob_nxt;
  logic         ol_r, ol_nxt;

  logic        can_send;
  logic [12:0] maxb;
  logic [7:0]  pbyte;

  assign can_send = !ov_r || !out_stall;
  assign maxb     = (limit_r == 13'd0) ? 13'd0 : limit_r - 13'd1;
  assign pbyte    = (cmd.sel == SEL_VOL) ? vol_r[{cmd.vidx, 3'b000} +: 8] : cmd.lit;

  assign stat.rdy     = can_send && !pend_r;
  assign stat.vol_len = (vol_len_r > 6'(LEN_CAP)) ? 6'(LEN_CAP) : vol_len_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_len_r       <= 6'd12;
      vol_r[63:0]     <= 64'd8316995054339940685;
      vol_r[127:64]   <= 64'd1145577576;
      vol_r[255:128]  <= '0;
      limit_r         <= 13'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOL_LEN: vol_len_r       <= cfg_data[5:0];
        REG_WORD0:   vol_r[63:0]     <= cfg_data;
        REG_WORD1:   vol_r[127:64]   <= cfg_data;
        REG_WORD2:   vol_r[191:128]  <= cfg_data;
        REG_WORD3:   vol_r[255:192]  <= cfg_data;
        REG_LIMIT:   limit_r         <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Push / finish / terminate operations
  always_comb begin
    held_nxt      = held_r;
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_byte_nxt = pend_byte_r;
    ov_nxt        = ov_r && out_stall;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;
    if (pend_r && can_send) begin
      ov_nxt   = 1'b1;
      ob_nxt   = pend_byte_r;
      ol_nxt   = 1'b0;
      prev_nxt = pend_byte_r;
      pend_nxt = 1'b0;
    end else if (cmd.go && stat.rdy) begin
      case (cmd.op)
        OP_PUSH: begin
          if (cnt_r < maxb) begin
            cnt_nxt = cnt_r + 13'd1;
            if (held_r) begin
              ov_nxt   = 1'b1;
              ob_nxt   = CH_COLON;
              ol_nxt   = 1'b0;
              prev_nxt = CH_COLON;
              if (pbyte != CH_COLON) begin
                held_nxt      = 1'b0;
                pend_nxt      = 1'b1;
                pend_byte_nxt = pbyte;
              end
            end else if (pbyte == CH_COLON) begin
              held_nxt = 1'b1;
            end else begin
              ov_nxt   = 1'b1;
              ob_nxt   = pbyte;
              ol_nxt   = 1'b0;
              prev_nxt = pbyte;
            end
          end
        end
        OP_FHELD: begin
          // trailing colon dropped unless it stands alone or follows a colon
          if (held_r && !(cnt_r >= 13'd2 && prev_r != CH_COLON)) begin
            ov_nxt = 1'b1;
            ob_nxt = CH_COLON;
            ol_nxt = 1'b0;
          end
          held_nxt = 1'b0;
        end
        OP_TERM: begin
          ov_nxt   = 1'b1;
          ob_nxt   = 8'h00;
          ol_nxt   = 1'b1;
          held_nxt = 1'b0;
          prev_nxt = 8'h00;
          cnt_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      prev_r <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      held_r <= held_nxt;
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    ob_r        <= ob_nxt;
    ol_r        <= ol_nxt;
  end

  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_last_of_path = ol_r;

endmodule

[rtl/pcc_ctrl.sv]
// Controller: path phase, input beat capture and push sequencing.
module pcc_ctrl import pcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_path,
  input  pcc_stat_t  stat,
  output pcc_cmd_t   cmd
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FEED  = 3'd1;
  localparam logic [2:0] S_VOL   = 3'd2;
  localparam logic [2:0] S_VCOL  = 3'd3;
  localparam logic [2:0] S_REP   = 3'd4;
  localparam logic [2:0] S_FINPH = 3'd5;
  localparam logic [2:0] S_FHELD = 3'd6;
  localparam logic [2:0] S_TERM  = 3'd7;

  // Path phases
  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_VOL        = 4'd1;
  localparam logic [3:0] PH_REL_DOT    = 4'd2;
  localparam logic [3:0] PH_REL_DOTDOT = 4'd3;
  localparam logic [3:0] PH_NORMAL     = 4'd4;
  localparam logic [3:0] PH_SLASH      = 4'd5;
  localparam logic [3:0] PH_SL_DOT     = 4'd6;
  localparam logic [3:0] PH_SL_DOTDOT  = 4'd7;
  localparam logic [3:0] PH_DOT_OWE    = 4'd8;

  logic [2:0] st_r, st_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic [2:0] la_r, la_nxt;
  logic [5:0] i_r, i_nxt;
  logic       vfin_r, vfin_nxt;
  logic [7:0] c_r;
  logic       eop_r;
  logic       acc;

  assign in_stall = (st_r != S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    la_nxt   = la_r;
    i_nxt    = i_r;
    vfin_nxt = vfin_r;
    cmd.go   = 1'b0;
    cmd.op   = OP_NONE;
    cmd.sel  = SEL_LIT;
    cmd.lit  = c_r;
    cmd.vidx = i_r[4:0];
    case (st_r)
      S_IDLE: begin
        if (acc) st_nxt = (in_byte == 8'h00) ? S_FINPH : S_FEED;
      end
      S_FEED: begin
        if (stat.rdy) begin
          // one conversion step; stays in S_FEED when the byte is fed again
          st_nxt = eop_r ? S_FINPH : S_IDLE;
          case (ph_r)
            PH_START: begin
              if (c_r == CH_SLASH) begin
                ph_nxt = PH_VOL;
                la_nxt = '0;
              end else begin
                cmd.go  = 1'b1;
                cmd.op  = OP_PUSH;
                cmd.lit = CH_COLON;
                if (c_r == CH_DOT) ph_nxt = PH_REL_DOT;
                else begin
                  ph_nxt = PH_NORMAL;
                  st_nxt = S_FEED;
                end
              end
            end
            PH_VOL: begin
              if (c_r == vol_prefix(la_r)) begin
                la_nxt = la_r + 3'd1;
                if (la_r == 3'(LA_DEPTH - 1)) ph_nxt = PH_NORMAL;
              end else begin
                st_nxt   = S_VOL;
                i_nxt    = '0;
                vfin_nxt = 1'b0;
              end
            end
            PH_REL_DOT: begin
              if (c_r == CH_SLASH) ph_nxt = PH_NORMAL;
              else if (c_r == CH_DOT) ph_nxt = PH_REL_DOTDOT;
              else begin
                cmd.go  = 1'b1;
                cmd.op  = OP_PUSH;
                cmd.lit = CH_DOT;
                ph_nxt  = PH_NORMAL;
                st_nxt  = S_FEED;
              end
            end
            PH_REL_DOTDOT, PH_SL_DOTDOT: begin
              cmd.go = 1'b1;
              cmd.op = OP_PUSH;
              if (c_r == CH_SLASH) begin
                cmd.lit = CH_COLON;
                ph_nxt  = PH_NORMAL;
              end else begin
                cmd.lit = CH_DOT;
                ph_nxt  = PH_DOT_OWE;
                st_nxt  = S_FEED;
              end
            end
            PH_DOT_OWE: begin
              cmd.go  = 1'b1;
              cmd.op  = OP_PUSH;
              cmd.lit = CH_DOT;
              ph_nxt  = PH_NORMAL;
              st_nxt  = S_FEED;
            end
            PH_SLASH: begin
              if (c_r == CH_DOT) ph_nxt = PH_SL_DOT;
              else if (c_r != CH_SLASH) begin
                cmd.go = 1'b1;
                cmd.op = OP_PUSH;
                ph_nxt = PH_NORMAL;
              end
            end
            PH_SL_DOT: begin
              if (c_r == CH_DOT) ph_nxt = PH_SL_DOTDOT;
              else begin
                cmd.go  = 1'b1;
                cmd.op  = OP_PUSH;
                cmd.lit = CH_DOT;
                ph_nxt  = PH_NORMAL;
                st_nxt  = S_FEED;
              end
            end
            default: begin
              cmd.go = 1'b1;
              cmd.op = OP_PUSH;
              if (c_r == CH_SLASH) begin
                cmd.lit = CH_COLON;
                ph_nxt  = PH_SLASH;
              end else begin
                ph_nxt = PH_NORMAL;
              end
            end
          endcase
        end
      end
      S_VOL: begin
        // default volume name, one byte a step
        if (i_r >= stat.vol_len) st_nxt = S_VCOL;
        else if (stat.rdy) begin
          cmd.go  = 1'b1;
          cmd.op  = OP_PUSH;
          cmd.sel = SEL_VOL;
          i_nxt   = i_r + 6'd1;
        end
      end
      S_VCOL: begin
        if (stat.rdy) begin
          cmd.go  = 1'b1;
          cmd.op  = OP_PUSH;
          cmd.lit = CH_COLON;
          i_nxt   = '0;
          st_nxt  = S_REP;
        end
      end
      S_REP: begin
        // replay the matched part of the prefix
        if (i_r >= {3'b000, la_r}) begin
          la_nxt = '0;
          ph_nxt = PH_NORMAL;
          st_nxt = vfin_r ? S_FHELD : S_FEED;
        end else if (stat.rdy) begin
          cmd.go  = 1'b1;
          cmd.op  = OP_PUSH;
          cmd.lit = vol_prefix(i_r[2:0]);
          i_nxt   = i_r + 6'd1;
        end
      end
      S_FINPH: begin
        if (ph_r == PH_VOL) begin
          vfin_nxt = 1'b1;
          i_nxt    = '0;
          st_nxt   = S_VOL;
        end else if (stat.rdy) begin
          st_nxt = S_FHELD;
          if (ph_r == PH_REL_DOTDOT || ph_r == PH_SL_DOTDOT) begin
            cmd.go  = 1'b1;
            cmd.op  = OP_PUSH;
            cmd.lit = CH_COLON;
          end else if (ph_r == PH_SL_DOT) begin
            cmd.go  = 1'b1;
            cmd.op  = OP_PUSH;
            cmd.lit = CH_DOT;
          end
        end
      end
      S_FHELD: begin
        if (stat.rdy) begin
          cmd.go = 1'b1;
          cmd.op = OP_FHELD;
          st_nxt = S_TERM;
        end
      end
      default: begin
        if (stat.rdy) begin
          cmd.go = 1'b1;
          cmd.op = OP_TERM;
          ph_nxt = PH_START;
          la_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ph_r   <= PH_START;
      la_r   <= '0;
      i_r    <= '0;
      vfin_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      la_r   <= la_nxt;
      i_r    <= i_nxt;
      vfin_r <= vfin_nxt;
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (acc) begin
      c_r   <= in_byte;
      eop_r <= in_end_of_path;
    end
  end

endmodule

[rtl/posix_to_colon_path_converter_unit.sv]
// Top level of the slash-path to colon-path converter.
// Takes one path byte per input beat and streams the colon path, ending each path with a
// zero beat flagged last_of_path. An ordinary byte is captured, then handled in one push
// step; in_stall holds off the next byte until the controller is idle. Most output bytes
// cost one push step (a byte held behind a released colon goes out without one), so the
// path head (default volume name, colon and replayed prefix) and the end of path
// (finish, trailing colon check, terminator: three steps) take longer. The output
// register holds a beat on out_stall; the controller then waits at each step needing rdy.
module posix_to_colon_path_converter_unit import pcc_pkg::*; #(
  parameter int VOLUME_MAX_BYTES = VOL_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_path,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_path,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  pcc_cmd_t  cmd;
  pcc_stat_t stat;

  pcc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .in_end_of_path(in_end_of_path),
    .stat(stat), .cmd(cmd)
  );

  pcc_dpath #(.VOLUME_MAX_BYTES(VOLUME_MAX_BYTES)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_last_of_path(out_last_of_path)
  );

endmodule

[rtl/pcc_checker.sv]
// Port-level checker for the converter, bound to the top level.
module pcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_path
);

  // an accepted input beat is followed by in_stall
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("input taken back to back");

  // the terminator beat is always a zero byte
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_path) |-> (out_byte == 8'h00)) else $error("bad terminator");

  // nothing shows on the output right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
      && $stable(out_last_of_path))) else $error("stalled beat changed");

endmodule

bind posix_to_colon_path_converter_unit pcc_checker u_pcc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
  .out_last_of_path(out_last_of_path)
);
